[rtl/core/ptl_pkg.sv]
// Shared widths, types and saturation helpers of the point-to-line projection pipeline.
package ptl_pkg;

    // Coordinate width; all other widths follow from it.
    localparam int CW    = 32;
    localparam int DW    = CW + 1;          // difference of two coordinates
    localparam int PRW   = 2 * DW;          // signed product of two differences
    localparam int SUMW  = PRW + 2;         // sum of three products
    localparam int MAGW  = 2 * DW;          // magnitude of a dot product
    localparam int QB    = CW + 2;          // quotient bits of the projection offset
    localparam int DVW   = MAGW + 1;        // divisor, twice the squared length
    localparam int NW    = QB + DVW;        // dividend
    localparam int OFW   = QB + 1;          // signed offset along one axis
    localparam int RW    = CW + 3;          // residual component
    localparam int SQI   = 2 * RW;          // square root radicand
    localparam int SQO   = RW;              // square root result
    localparam int SRW   = SQO + 2;         // square root partial remainder
    localparam int NSW   = CW + 4;          // unsaturated coordinate sum

    localparam logic [NSW-1:0] SMAX = {{(NSW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [NSW-1:0] SMIN = {{(NSW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } t_reg_idx;

    typedef logic [2:0][CW-1:0] t_vec;

    // Context that rides alongside the divider.
    typedef struct packed {
        t_vec                s;
        logic [2:0][DW-1:0]  p;
        logic [MAGW-1:0]     pp;
        logic [MAGW-1:0]     den;
        logic [2:0]          off_neg;
        logic                degen;
        logic                sd_pos;
    } t_mid;

    // Context that rides alongside the square root units.
    typedef struct packed {
        t_vec  nearest;
        logic  sd_pos;
        logic  degen;
    } t_tail;

    function automatic logic [CW-1:0] sat_coord(input logic [NSW-1:0] v);
        logic [CW-1:0] res;
        if ($signed(v) > $signed(SMAX)) begin
            res = SMAX[CW-1:0];
        end else if ($signed(v) < $signed(SMIN)) begin
            res = SMIN[CW-1:0];
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    function automatic logic [CW-2:0] sat_len(input logic [SQO-1:0] v);
        logic [CW-2:0] res;
        if (|v[SQO-1:CW-1]) begin
            res = {(CW-1){1'b1}};
        end else begin
            res = v[CW-2:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/ptl_front.sv]
// Front end: differences, dot products and the dividends of the projection.
module ptl_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  ptl_pkg::t_vec                      i_point,
    input  ptl_pkg::t_vec                      i_start,
    input  ptl_pkg::t_vec                      i_end,
    output logic                               o_valid,
    output ptl_pkg::t_mid                      o_mid,
    output logic [2:0][ptl_pkg::NW-1:0]        o_numer
);
    import ptl_pkg::*;

    logic [5:0] r_v;

    logic [2:0][DW-1:0] r1_d, r1_p;
    t_vec               r1_s;
    logic [2:0][DW-1:0] n1_d, n1_p;

    logic [PRW-1:0]     r2_dd [3];
    logic [PRW-1:0]     r2_dp [3];
    logic [PRW-1:0]     r2_pq [3];
    logic [2:0][DW-1:0] r2_d, r2_p;
    t_vec               r2_s;

    logic [SUMW-1:0]    r3_den, r3_num, r3_pp;
    logic [2:0][DW-1:0] r3_d, r3_p;
    t_vec               r3_s;

    t_mid               r4_mid, n4_mid;
    logic [2:0][DW-1:0] r4_dabs, n4_dabs;
    logic [MAGW-1:0]    r4_nmag, n4_nmag;

    t_mid               r5_mid;
    logic [2*DW-1:0]    r5_lo [3];
    logic [2*DW-1:0]    r5_hi [3];

    logic [2:0][NW-1:0] n6_numer;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_d[i] = {i_end[i][CW-1], i_end[i]} - {i_start[i][CW-1], i_start[i]};
            n1_p[i] = {i_point[i][CW-1], i_point[i]} - {i_start[i][CW-1], i_start[i]};
        end
    end

    always_comb begin
        logic num_neg;
        num_neg = r3_num[SUMW-1];
        n4_nmag = num_neg ? MAGW'(~r3_num + 1'b1) : r3_num[MAGW-1:0];
        n4_mid.s      = r3_s;
        n4_mid.p      = r3_p;
        n4_mid.pp     = r3_pp[MAGW-1:0];
        n4_mid.den    = r3_den[MAGW-1:0];
        n4_mid.degen  = (r3_den == '0);
        n4_mid.sd_pos = !num_neg && (r3_num != '0);
        for (int i = 0; i < 3; i++) begin
            n4_dabs[i]        = r3_d[i][DW-1] ? (~r3_d[i] + 1'b1) : r3_d[i];
            n4_mid.off_neg[i] = r3_d[i][DW-1] ^ num_neg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n6_numer[i] = (((NW'(r5_hi[i]) << DW) + NW'(r5_lo[i])) << 1)
                          + NW'(r5_mid.den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[4:0], i_valid};
            o_valid <= r_v[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d <= n1_d;
            r1_p <= n1_p;
            r1_s <= i_start;

            for (int i = 0; i < 3; i++) begin
                r2_dd[i] <= $signed(r1_d[i]) * $signed(r1_d[i]);
                r2_dp[i] <= $signed(r1_d[i]) * $signed(r1_p[i]);
                r2_pq[i] <= $signed(r1_p[i]) * $signed(r1_p[i]);
            end
            r2_d <= r1_d;
            r2_p <= r1_p;
            r2_s <= r1_s;

            r3_den <= SUMW'($signed(r2_dd[0])) + SUMW'($signed(r2_dd[1]))
                      + SUMW'($signed(r2_dd[2]));
            r3_num <= SUMW'($signed(r2_dp[0])) + SUMW'($signed(r2_dp[1]))
                      + SUMW'($signed(r2_dp[2]));
            r3_pp  <= SUMW'($signed(r2_pq[0])) + SUMW'($signed(r2_pq[1]))
                      + SUMW'($signed(r2_pq[2]));
            r3_d   <= r2_d;
            r3_p   <= r2_p;
            r3_s   <= r2_s;

            r4_mid  <= n4_mid;
            r4_dabs <= n4_dabs;
            r4_nmag <= n4_nmag;

            // The magnitude of d.p is split in two halves for the multiplier.
            for (int i = 0; i < 3; i++) begin
                r5_lo[i] <= r4_dabs[i] * r4_nmag[DW-1:0];
                r5_hi[i] <= r4_dabs[i] * r4_nmag[MAGW-1:DW];
            end
            r5_mid <= r4_mid;

            o_numer <= n6_numer;
            o_mid   <= r5_mid;
        end
    end

endmodule

[rtl/core/ptl_div.sv]
// Pipelined restoring divider, one quotient bit per stage on all three axes.
module ptl_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  ptl_pkg::t_mid                      i_mid,
    input  logic [2:0][ptl_pkg::NW-1:0]        i_numer,
    output logic                               o_valid,
    output ptl_pkg::t_mid                      o_mid,
    output logic [2:0][ptl_pkg::QB-1:0]        o_quot
);
    import ptl_pkg::*;

    logic [QB-1:0]       r_v;
    t_mid                r_mid [QB];
    logic [2:0][DVW-1:0] r_rem [QB];
    logic [2:0][QB-1:0]  r_low [QB];
    logic [2:0][QB-1:0]  r_q   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic                a_v;
        t_mid                a_mid;
        logic [2:0][DVW-1:0] a_rem, n_rem;
        logic [2:0][QB-1:0]  a_low, n_low, a_q, n_q;
        logic [DVW-1:0]      dvs;

        if (k == 0) begin : g_first
            // The quotient is known to fit QB bits, so the top of the dividend
            // already lies below the divisor.
            assign a_v   = i_valid;
            assign a_mid = i_mid;
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign a_rem[j] = i_numer[j][NW-1:QB];
                assign a_low[j] = i_numer[j][QB-1:0];
                assign a_q[j]   = '0;
            end
        end else begin : g_next
            assign a_v   = r_v[k-1];
            assign a_mid = r_mid[k-1];
            assign a_rem = r_rem[k-1];
            assign a_low = r_low[k-1];
            assign a_q   = r_q[k-1];
        end

        assign dvs = {a_mid.den, 1'b0};

        always_comb begin
            logic [DVW:0] sh;
            for (int j = 0; j < 3; j++) begin
                sh = {a_rem[j], a_low[j][QB-1]};
                if (sh >= {1'b0, dvs}) begin
                    n_rem[j] = DVW'(sh - {1'b0, dvs});
                    n_q[j]   = {a_q[j][QB-2:0], 1'b1};
                end else begin
                    n_rem[j] = sh[DVW-1:0];
                    n_q[j]   = {a_q[j][QB-2:0], 1'b0};
                end
                n_low[j] = {a_low[j][QB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mid[k] <= a_mid;
                r_rem[k] <= n_rem;
                r_low[k] <= n_low;
                r_q[k]   <= n_q;
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_mid   = r_mid[QB-1];
    assign o_quot  = r_q[QB-1];

endmodule

[rtl/core/ptl_perp.sv]
// Offsets, nearest point, residual and its squared length.
module ptl_perp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  ptl_pkg::t_mid                      i_mid,
    input  logic [2:0][ptl_pkg::QB-1:0]        i_quot,
    output logic                               o_valid,
    output ptl_pkg::t_tail                     o_tail,
    output logic [2:0][ptl_pkg::SQI-1:0]       o_rad
);
    import ptl_pkg::*;

    logic [2:0]          r_v;

    t_mid                r1_mid;
    logic [2:0][OFW-1:0] r1_off, n1_off;

    t_tail               r2_tail, n2_tail;
    logic [2:0][RW-1:0]  r2_r, n2_r;
    logic [MAGW-1:0]     r2_pp, r2_den;

    t_tail               r3_tail;
    logic [SQI-1:0]      r3_sq [3];
    logic [MAGW-1:0]     r3_pp, r3_den;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_mid.degen) begin
                n1_off[i] = '0;
            end else if (i_mid.off_neg[i]) begin
                n1_off[i] = ~{1'b0, i_quot[i]} + 1'b1;
            end else begin
                n1_off[i] = {1'b0, i_quot[i]};
            end
        end
    end

    always_comb begin
        n2_tail.sd_pos = r1_mid.sd_pos;
        n2_tail.degen  = r1_mid.degen;
        for (int i = 0; i < 3; i++) begin
            n2_r[i] = RW'(NSW'($signed(r1_mid.p[i])) - NSW'($signed(r1_off[i])));
            n2_tail.nearest[i] = sat_coord(NSW'($signed(r1_mid.s[i]))
                                           + NSW'($signed(r1_off[i])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[1:0], i_valid};
            o_valid <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mid  <= i_mid;
            r1_off  <= n1_off;

            r2_tail <= n2_tail;
            r2_r    <= n2_r;
            r2_pp   <= r1_mid.pp;
            r2_den  <= r1_mid.den;

            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= $signed(r2_r[i]) * $signed(r2_r[i]);
            end
            r3_tail <= r2_tail;
            r3_pp   <= r2_pp;
            r3_den  <= r2_den;

            o_tail   <= r3_tail;
            o_rad[0] <= r3_sq[0] + r3_sq[1] + r3_sq[2];
            o_rad[1] <= SQI'(r3_pp);
            o_rad[2] <= SQI'(r3_den);
        end
    end

endmodule

[rtl/core/ptl_sqrt.sv]
// Three pipelined digit-by-digit integer square roots, one result bit per stage.
module ptl_sqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  ptl_pkg::t_tail                     i_tail,
    input  logic [2:0][ptl_pkg::SQI-1:0]       i_rad,
    output logic                               o_valid,
    output ptl_pkg::t_tail                     o_tail,
    output logic [2:0][ptl_pkg::SQO-1:0]       o_root
);
    import ptl_pkg::*;

    logic [SQO-1:0]      r_v;
    t_tail               r_tail [SQO];
    logic [2:0][SQI-1:0] r_rad  [SQO];
    logic [2:0][SRW-1:0] r_rem  [SQO];
    logic [2:0][SQO-1:0] r_root [SQO];

    for (genvar k = 0; k < SQO; k++) begin : g_stage
        logic                a_v;
        t_tail               a_tail;
        logic [2:0][SQI-1:0] a_rad, n_rad;
        logic [2:0][SRW-1:0] a_rem, n_rem;
        logic [2:0][SQO-1:0] a_root, n_root;

        if (k == 0) begin : g_first
            assign a_v    = i_valid;
            assign a_tail = i_tail;
            assign a_rad  = i_rad;
            assign a_rem  = '0;
            assign a_root = '0;
        end else begin : g_next
            assign a_v    = r_v[k-1];
            assign a_tail = r_tail[k-1];
            assign a_rad  = r_rad[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_root = r_root[k-1];
        end

        always_comb begin
            logic [SRW+1:0] cur;
            logic [SRW+1:0] trial;
            for (int j = 0; j < 3; j++) begin
                cur   = {a_rem[j], a_rad[j][SQI-1 -: 2]};
                trial = {2'b00, a_root[j], 2'b01};
                if (cur >= trial) begin
                    n_rem[j]  = SRW'(cur - trial);
                    n_root[j] = {a_root[j][SQO-2:0], 1'b1};
                end else begin
                    n_rem[j]  = cur[SRW-1:0];
                    n_root[j] = {a_root[j][SQO-2:0], 1'b0};
                end
                n_rad[j] = {a_rad[j][SQI-3:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tail[k] <= a_tail;
                r_rad[k]  <= n_rad;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_valid = r_v[SQO-1];
    assign o_tail  = r_tail[SQO-1];
    assign o_root  = r_root[SQO-1];

endmodule

[rtl/core/point_to_line_projection.sv]
// Top level of the point-to-line projection pipeline with its register file.
//
// Each request on the slave stream carries a query point P in signed Q15.16
// and returns one request on the master stream holding the closest point on
// the infinite line through the configured endpoints S and E, the
// perpendicular distance from P to that line, the distance from P to S signed
// positive only when (P-S).(E-S) is strictly positive, the length of S-E and a
// flag raised when S and E coincide (the closest point is then S). Every
// result saturates to its field. The block takes a new request every clock
// cycle and each request passes through six front-end stages for
// the differences, the three dot products and the dividends, thirty-four
// divider stages (one quotient bit per stage on the three axes), four stages
// for the offsets and the squared residual, thirty-five square root stages
// (one root bit per stage) and the output register. A stalled master side
// freezes the whole pipeline, so nothing is dropped or repeated. The endpoint
// registers must only be written while no request is in flight.
module point_to_line_projection (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Slave stream. tdata: point_x [31:0], point_y [63:32], point_z [95:64].
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [95:0]   i_s_tdata,
    // Master stream. tdata: nearest_x [31:0], nearest_y [63:32],
    // nearest_z [95:64], perpendicular_distance [126:96],
    // signed_start_distance [158:127], segment_length [189:159], zero pad.
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [191:0]  o_m_tdata,
    // tuser: degenerate [0].
    output logic [0:0]    o_m_tuser,
    // Register write port.
    input  logic          i_cfg_wen,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_wdata
);
    import ptl_pkg::*;

    // Endpoint registers; the second endpoint resets to (1.0, 0, 0).
    t_vec r_start;
    t_vec r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= {CW'(0), CW'(0), CW'(32'h0001_0000)};
        end else if (i_cfg_wen) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_START_X: r_start[0] <= i_cfg_wdata;
                REG_START_Y: r_start[1] <= i_cfg_wdata;
                REG_START_Z: r_start[2] <= i_cfg_wdata;
                REG_END_X:   r_end[0]   <= i_cfg_wdata;
                REG_END_Y:   r_end[1]   <= i_cfg_wdata;
                REG_END_Z:   r_end[2]   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // One enable for every stage: the pipeline moves whenever the output
    // register is empty or being emptied.
    logic adv;
    logic r_out_v;

    assign adv        = !r_out_v || i_m_tready;
    assign o_s_tready = adv;

    t_vec               in_point;
    logic               fr_v;
    t_mid               fr_mid;
    logic [2:0][NW-1:0] fr_numer;
    logic               dv_v;
    t_mid               dv_mid;
    logic [2:0][QB-1:0] dv_quot;
    logic               pp_v;
    t_tail              pp_tail;
    logic [2:0][SQI-1:0] pp_rad;
    logic               sq_v;
    t_tail              sq_tail;
    logic [2:0][SQO-1:0] sq_root;

    assign in_point[0] = i_s_tdata[31:0];
    assign in_point[1] = i_s_tdata[63:32];
    assign in_point[2] = i_s_tdata[95:64];

    ptl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_s_tvalid),
        .i_point (in_point),
        .i_start (r_start),
        .i_end   (r_end),
        .o_valid (fr_v),
        .o_mid   (fr_mid),
        .o_numer (fr_numer)
    );

    ptl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (fr_v),
        .i_mid   (fr_mid),
        .i_numer (fr_numer),
        .o_valid (dv_v),
        .o_mid   (dv_mid),
        .o_quot  (dv_quot)
    );

    ptl_perp u_perp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (dv_v),
        .i_mid   (dv_mid),
        .i_quot  (dv_quot),
        .o_valid (pp_v),
        .o_tail  (pp_tail),
        .o_rad   (pp_rad)
    );

    // Root lanes: perpendicular distance, distance to S, segment length.
    ptl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (pp_v),
        .i_tail  (pp_tail),
        .i_rad   (pp_rad),
        .o_valid (sq_v),
        .o_tail  (sq_tail),
        .o_root  (sq_root)
    );

    // Output register with the final saturation.
    logic [NSW-1:0] sd_full;
    logic [191:0]   n_out_data;
    logic [191:0]   r_out_data;
    logic           r_out_degen;

    assign sd_full = sq_tail.sd_pos ? NSW'({1'b0, sq_root[1]})
                                    : NSW'(~{1'b0, sq_root[1]} + 1'b1);

    always_comb begin
        n_out_data = '0;
        n_out_data[31:0]    = sq_tail.nearest[0];
        n_out_data[63:32]   = sq_tail.nearest[1];
        n_out_data[95:64]   = sq_tail.nearest[2];
        n_out_data[126:96]  = sat_len(sq_root[0]);
        n_out_data[158:127] = sat_coord(sd_full);
        n_out_data[189:159] = sat_len(sq_root[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data  <= n_out_data;
            r_out_degen <= sq_tail.degen;
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_degen;

    // A held result must stop the intake.
    a_stall_blocks_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("intake open while a result is held");

    // Coincident endpoints always give a zero segment length.
    a_degen_zero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[189:159] == '0)
        else $error("degenerate line with nonzero length");

    // Coincident endpoints give a zero product, so the signed distance is not positive.
    a_degen_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[158] || o_m_tdata[158:127] == '0)
        else $error("degenerate line with positive start distance");

endmodule

[sim/ptl_checker.sv]
// Monitor, line-projection predictor and result comparator for the projection pipeline.
`timescale 1ns / 100ps
module ptl_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    input  logic [95:0]   i_s_tdata,
    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    input  logic [191:0]  i_m_tdata,
    input  logic [0:0]    i_m_tuser,
    input  logic          i_cfg_wen,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_wdata,
    output int            o_errors,
    output int            o_pending
);
    import ptl_pkg::*;

    localparam logic [31:0]         ONE_Q16 = 32'h0001_0000;
    localparam logic signed [255:0] COORD_MAX = 256'sd2147483647;
    localparam logic signed [255:0] COORD_MIN = -256'sd2147483648;
    localparam logic signed [255:0] LEN_MAX = 256'sd2147483647;

    typedef struct packed {
        logic [31:0] nearest_x;
        logic [31:0] nearest_y;
        logic [31:0] nearest_z;
        logic [30:0] perp_dist;
        logic [31:0] start_dist;
        logic [30:0] seg_len;
        logic        degen;
    } t_projection;

    logic [31:0]  endpoint_reg [6];
    t_projection  projections_due [$];
    int           errors = 0;

    assign o_errors  = errors;
    assign o_pending = projections_due.size();

    function automatic logic [63:0] floor_sqrt(input logic [255:0] n);
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [255:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            sq = 256'(cand) * 256'(cand);
            if (sq <= n) root = cand;
        end
        return root;
    endfunction

    function automatic logic [31:0] clamp_coord(input logic signed [255:0] v);
        logic [31:0] res;
        if (v > COORD_MAX) res = COORD_MAX[31:0];
        else if (v < COORD_MIN) res = COORD_MIN[31:0];
        else res = v[31:0];
        return res;
    endfunction

    function automatic logic [30:0] clamp_len(input logic signed [255:0] v);
        logic [30:0] res;
        res = (v > LEN_MAX) ? LEN_MAX[30:0] : v[30:0];
        return res;
    endfunction

    function automatic t_projection project_point(input logic [95:0] pt);
        logic signed [255:0] s [3];
        logic signed [255:0] d [3];
        logic signed [255:0] p [3];
        logic signed [255:0] off [3];
        logic signed [255:0] r [3];
        logic signed [255:0] num, den, pp, perp, num_mag, d_mag, quo, start_len;
        logic [63:0]         len;
        t_projection         res;
        num = 0; den = 0; pp = 0; perp = 0;
        for (int i = 0; i < 3; i++) begin
            s[i] = $signed(endpoint_reg[i]);
            d[i] = $signed(endpoint_reg[i+3]) - s[i];
            p[i] = $signed(pt[32*i +: 32]) - s[i];
            num += d[i] * p[i];
            den += d[i] * d[i];
            pp  += p[i] * p[i];
        end
        num_mag = (num < 0) ? -num : num;
        for (int i = 0; i < 3; i++) begin
            off[i] = 0;
            if (den != 0 && num != 0 && d[i] != 0) begin
                // Rounded half away from zero by adding half the divisor.
                d_mag = (d[i] < 0) ? -d[i] : d[i];
                quo = (2 * d_mag * num_mag + den) / (2 * den);
                off[i] = ((d[i] < 0) != (num < 0)) ? -quo : quo;
            end
            r[i] = p[i] - off[i];
            perp += r[i] * r[i];
        end
        res.nearest_x = clamp_coord(s[0] + off[0]);
        res.nearest_y = clamp_coord(s[1] + off[1]);
        res.nearest_z = clamp_coord(s[2] + off[2]);
        res.perp_dist = clamp_len($signed({192'd0, floor_sqrt(perp)}));
        len = floor_sqrt(pp);
        start_len = $signed({192'd0, len});
        // A zero product counts as pointing away from the line direction.
        res.start_dist = clamp_coord((num > 0) ? start_len : -start_len);
        res.seg_len = clamp_len($signed({192'd0, floor_sqrt(den)}));
        res.degen = (den == 0);
        return res;
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_projection want;
        if (!i_rst_n) begin
            endpoint_reg <= '{32'd0, 32'd0, 32'd0, ONE_Q16, 32'd0, 32'd0};
        end else begin
            if (i_cfg_wen && i_cfg_idx <= 3'(REG_END_Z)) begin
                endpoint_reg[i_cfg_idx] <= i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (projections_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("%0t result with none outstanding", $realtime);
                end else begin
                    want = projections_due.pop_front();
                    report("nearest_x", want.nearest_x, i_m_tdata[31:0]);
                    report("nearest_y", want.nearest_y, i_m_tdata[63:32]);
                    report("nearest_z", want.nearest_z, i_m_tdata[95:64]);
                    report("perpendicular_distance", 32'(want.perp_dist), 32'(i_m_tdata[126:96]));
                    report("signed_start_distance", want.start_dist, i_m_tdata[158:127]);
                    report("segment_length", 32'(want.seg_len), 32'(i_m_tdata[189:159]));
                    report("degenerate", 32'(want.degen), 32'(i_m_tuser[0]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                projections_due.push_back(project_point(i_s_tdata));
            end
        end
    end

endmodule

[sim/point_to_line_projection_tb.sv]
// Stimulus, endpoint programming and verdict for the point-to-line projection block.
`timescale 1ns / 100ps
module point_to_line_projection_tb;
    import ptl_pkg::*;

    // Indexes outside the register file; such writes must leave the endpoints alone.
    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic [2:0] REG_TOP    = 3'd7;
    localparam int PIPE_LATENCY = 100;
    localparam int STALL_LIMIT  = 20000;
    localparam logic [31:0] COORD_HI = 32'h7fff_ffff;
    localparam logic [31:0] COORD_LO = 32'h8000_0000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [95:0]   i_s_tdata;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [191:0]  o_m_tdata;
    logic [0:0]    o_m_tuser;
    logic          i_cfg_wen;
    logic [2:0]    i_cfg_idx;
    logic [31:0]   i_cfg_wdata;
    int            errors;
    int            pending;

    // Idle percentages of the two sides, changed as the run moves between phases.
    int            send_idle;
    int            recv_idle;
    int            stall_cycles = 0;

    point_to_line_projection DUT (.*);

    ptl_checker u_checker (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .i_cfg_wen, .i_cfg_idx, .i_cfg_wdata,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The receiver drops tready at random, at the rate the current phase sets.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: any long run of cycles with no request moving on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Random coordinate: mostly modest values so that projections stay in range,
    // with full-width values and the extremes mixed in to reach saturation.
    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = COORD_HI;
            1: v = COORD_LO;
            2, 3: v = $urandom;
            default: v = 32'($signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000);
        endcase
        return v;
    endfunction

    // Sends one point; called and returning at a falling edge. tvalid stays
    // high into the next request unless a gap is taken.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        if ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [31:0] sx, sy, sz;
        for (int n = 0; n < count; n++) begin
            sx = rand_coord();
            sy = rand_coord();
            sz = rand_coord();
            send_point(sx, sy, sz);
        end
    endtask

    // Waits until every outstanding request has come back and the pipeline is empty.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (PIPE_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    task automatic set_line(input logic [31:0] s[3], input logic [31:0] e[3]);
        write_reg(REG_START_X, s[0]);
        write_reg(REG_START_Y, s[1]);
        write_reg(REG_START_Z, s[2]);
        write_reg(REG_END_X, e[0]);
        write_reg(REG_END_Y, e[1]);
        write_reg(REG_END_Z, e[2]);
    endtask

    initial begin
        logic [31:0] s [3];
        logic [31:0] e [3];
        send_idle    = 27;
        recv_idle    = 77;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_cfg_wen    = 1'b0;
        i_cfg_idx    = REG_START_X;
        i_cfg_wdata  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed points on the reset line, the unit x axis.
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'h0001_0000, 32'd0, 32'd0);
        send_point(32'h0000_8000, 32'h0003_0000, 32'hfffc_0000);
        send_point(32'hffff_0000, 32'h0001_0000, 32'd0);
        send_point(32'd0, 32'h0002_0000, 32'h0002_0000);
        send_point(COORD_HI, COORD_HI, COORD_HI);
        send_point(COORD_LO, COORD_LO, COORD_LO);
        send_point(COORD_HI, COORD_LO, COORD_HI);
        send_point(COORD_LO, COORD_HI, 32'd0);
        send_point(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
        send_random(140);

        // Pause until everything is back, then junk writes that must be ignored.
        drain();
        write_reg(REG_UNUSED, 32'hdead_beef);
        write_reg(REG_TOP, 32'h1234_5678);
        send_point(32'h0002_0000, 32'h0001_0000, 32'd0);
        send_random(40);

        // Endpoints at opposite corners of the range.
        drain();
        s = '{COORD_HI, COORD_HI, COORD_HI};
        e = '{COORD_LO, COORD_LO, COORD_LO};
        set_line(s, e);
        send_point(COORD_HI, COORD_HI, COORD_HI);
        send_point(COORD_LO, COORD_LO, COORD_LO);
        send_point(32'd0, 32'd0, 32'd0);
        send_point(COORD_LO, COORD_HI, COORD_LO);
        send_random(120);

        // Coincident endpoints: no direction.
        drain();
        send_idle = 77;
        recv_idle = 27;
        s = '{32'h0001_0000, 32'hfffe_0000, 32'h0000_4000};
        set_line(s, s);
        send_point(32'h0001_0000, 32'hfffe_0000, 32'h0000_4000);
        send_point(COORD_HI, COORD_LO, COORD_HI);
        send_point(32'h0004_0000, 32'h0000_0000, 32'h0000_4000);
        send_random(120);

        // Random lines; from the third phase on, both sides run with no idle gaps.
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            if (ph == 2) begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int i = 0; i < 3; i++) begin
                s[i] = rand_coord();
                e[i] = ($urandom_range(3) == 0) ? s[i] : rand_coord();
            end
            set_line(s, e);
            send_point(s[0], s[1], s[2]);
            send_point(e[0], e[1], e[2]);
            send_random(100);
        end

        drain();
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
